>>> hw/rtl/alarm_timer_registers_top_defines.svh
// Assertion macros for the alarm timer register block.
// Used by the port checker; no other dependencies.
`ifndef ALARM_TIMER_REGISTERS_TOP_DEFINES_SVH
`define ALARM_TIMER_REGISTERS_TOP_DEFINES_SVH

// Generic clocked assertion with an active-low reset.
`define ATR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Assertion on the block clock and reset.
`define ATR_ASSERT_CR(lbl, prop) \
  `ATR_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

>>> hw/rtl/atr_pkg.sv
// Shared types and constants for the alarm timer register block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atr_pkg;

  // Width of the time counter and the alarm compare (33 to 64).
  localparam int unsigned TIME_W = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STEP_W = 20;
  localparam int unsigned OFF_W  = 8;

  // Register byte offsets.
  localparam logic [OFF_W-1:0] OFF_TIME_LOW   = 8'h00;
  localparam logic [OFF_W-1:0] OFF_TIME_HIGH  = 8'h04;
  localparam logic [OFF_W-1:0] OFF_ALARM_LOW  = 8'h08;
  localparam logic [OFF_W-1:0] OFF_ALARM_HIGH = 8'h0c;
  localparam logic [OFF_W-1:0] OFF_CLEAR_IRQ  = 8'h10;
  localparam logic [OFF_W-1:0] OFF_CLEAR_ALRM = 8'h14;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd1;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [OFF_W-1:0]  offset;
    logic [WORD_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq_level;
    logic              status;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/atr_if.sv
// Valid/ready channel interfaces for items and results.
// Depends on atr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface atr_item_if
  import atr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [OFF_W-1:0]  offset;
  logic [WORD_W-1:0] write_data;

  modport source (output valid, output mode, output offset, output write_data, input ready);
  modport sink   (input valid, input mode, input offset, input write_data, output ready);
endinterface

interface atr_result_if
  import atr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;
  logic              irq_level;
  logic              status;

  modport source (output valid, output read_data, output irq_level, output status, input ready);
  modport sink   (input valid, input read_data, input irq_level, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/alarm_timer_registers_top.sv
// Alarm timer register block: 64-bit microsecond counter with alarm.
// Throughput: one item per cycle while the result side keeps accepting; the
// counter add and alarm compare sit between the input register and the
// result register.
// Reset clears time, latch, alarm, armed flag and interrupt; tick step is 1.
// Depends on atr_pkg, atr_if, atr_in_stage, atr_core, atr_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module alarm_timer_registers_top
  import atr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [STEP_W-1:0] cfg_wdata_i,
  atr_item_if.sink               item_i,
  atr_result_if.source           result_o
);

  item_t   in_item, staged_item;
  result_t core_result, out_result;
  logic    fire, out_free;

  assign in_item.mode       = item_i.mode;
  assign in_item.offset     = item_i.offset;
  assign in_item.write_data = item_i.write_data;

  atr_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .in_item_i   (in_item),
    .down_free_i (out_free),
    .fire_o      (fire),
    .item_o      (staged_item)
  );

  atr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (staged_item),
    .result_o    (core_result)
  );

  atr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (core_result),
    .free_o      (out_free),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .result_o    (out_result)
  );

  assign result_o.read_data = out_result.read_data;
  assign result_o.irq_level = out_result.irq_level;
  assign result_o.status    = out_result.status;

endmodule

`default_nettype wire

>>> hw/rtl/atr_in_stage.sv
// Input register stage: captures one item per transfer and hands it on.
// Depends on atr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atr_in_stage
  import atr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  input  wire logic  down_free_i,
  output logic       fire_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;

  // Advance when the result slot can take the processed item.
  assign fire_o     = valid_q && down_free_i;
  assign in_ready_o = !valid_q || fire_o;
  assign item_o     = item_q;

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture payload on a transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atr_core.sv
// Timer state and register access logic: updates state for the staged item
// and forms its result. Depends on atr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atr_core
  import atr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [STEP_W-1:0] cfg_wdata_i,
  input  wire logic              fire_i,
  input  wire item_t             item_i,
  output result_t                result_o
);

  logic [STEP_W-1:0] step_q;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] latch_q, latch_d;
  logic [WORD_W-1:0] alarm_lo_q, alarm_lo_d;
  logic [WORD_W-1:0] alarm_hi_q, alarm_hi_d;
  logic              armed_q, armed_d;
  logic              irq_q, irq_d;

  logic [2*WORD_W-1:0] alarm_full_cur, alarm_full_wr;
  logic [TIME_W-1:0]   alarm_cur, alarm_wr, time_tick;
  logic [WORD_W-1:0]   rdata;
  logic                bad;
  mode_e               mode;

  // Assemble the alarm, masked to the counter width.
  assign alarm_full_cur = {alarm_hi_q, alarm_lo_q};
  assign alarm_full_wr  = {alarm_hi_q, item_i.write_data};
  assign alarm_cur      = alarm_full_cur[TIME_W-1:0];
  assign alarm_wr       = alarm_full_wr[TIME_W-1:0];
  assign time_tick      = time_q + TIME_W'(step_q);
  assign mode           = mode_e'(item_i.mode);

  // Decode the item and work out the next state.
  always_comb begin
    time_d     = time_q;
    latch_d    = latch_q;
    alarm_lo_d = alarm_lo_q;
    alarm_hi_d = alarm_hi_q;
    armed_d    = armed_q;
    irq_d      = irq_q;
    rdata      = '0;
    bad        = 1'b0;
    case (mode)
      MODE_TICK: begin
        time_d = time_tick;
        if (armed_q && (alarm_cur <= time_tick)) begin
          irq_d   = 1'b1;
          armed_d = 1'b0;
        end
      end
      MODE_READ: begin
        case (item_i.offset)
          OFF_TIME_LOW: begin
            latch_d = time_q;
            rdata   = time_q[WORD_W-1:0];
          end
          OFF_TIME_HIGH: rdata = WORD_W'(latch_q >> WORD_W);
          default:       bad   = 1'b1;
        endcase
      end
      MODE_WRITE: begin
        case (item_i.offset)
          OFF_ALARM_LOW: begin
            alarm_lo_d = item_i.write_data;
            if (alarm_wr <= time_q) begin
              irq_d = 1'b1;
            end else begin
              armed_d = 1'b1;
            end
          end
          OFF_ALARM_HIGH: alarm_hi_d = item_i.write_data;
          OFF_CLEAR_ALRM: begin
            armed_d = 1'b0;
            irq_d   = 1'b0;
          end
          OFF_CLEAR_IRQ: irq_d = 1'b0;
          default:       bad   = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
  end

  assign result_o.read_data = rdata;
  assign result_o.irq_level = irq_d;
  assign result_o.status    = bad;

  // Commit state when the item advances; take config writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_RESET;
      time_q     <= '0;
      latch_q    <= '0;
      alarm_lo_q <= '0;
      alarm_hi_q <= '0;
      armed_q    <= 1'b0;
      irq_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        time_q     <= time_d;
        latch_q    <= latch_d;
        alarm_lo_q <= alarm_lo_d;
        alarm_hi_q <= alarm_hi_d;
        armed_q    <= armed_d;
        irq_q      <= irq_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atr_out_stage.sv
// Result register: holds one result until the downstream transfer.
// Depends on atr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atr_out_stage
  import atr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      result_o
);

  logic    valid_q;
  result_t result_q;

  // Slot is free when empty or draining this cycle.
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Capture the new result.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atr_checker.sv
// Port-level checker for the alarm timer register block, bound to the top.
// Depends on atr_pkg and alarm_timer_registers_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "alarm_timer_registers_top_defines.svh"

module atr_checker
  import atr_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [WORD_W-1:0] read_data_i,
  input wire logic              irq_level_i,
  input wire logic              status_i
);

  // A stalled result stays offered.
  `ATR_ASSERT_CR(a_out_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  // A stalled result keeps its payload.
  `ATR_ASSERT_CR(a_out_stable, out_valid_i && !out_ready_i |=> $stable({read_data_i, irq_level_i, status_i}))
  // An accepted item has a result on offer once it has passed the input and result registers.
  `ATR_ASSERT_CR(a_in_to_out, in_valid_i && in_ready_i |-> ##2 out_valid_i)
  // A failed access returns no read data.
  `ATR_ASSERT_CR(a_bad_zero, out_valid_i && status_i |-> read_data_i == '0)

endmodule

bind alarm_timer_registers_top atr_checker u_atr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .read_data_i (result_o.read_data),
  .irq_level_i (result_o.irq_level),
  .status_i    (result_o.status)
);

`default_nettype wire

>>> dv/alarm_timer_registers_top_test.sv
// Self-checking testbench for the alarm timer register block.
// Depends on atr_pkg, atr_if and alarm_timer_registers_top from the RTL.
`timescale 1ns / 1ps

module alarm_timer_registers_top_test;
  import atr_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;

  // One directed row: item, whether the result is typed in, and that result
  typedef struct packed {
    item_t   it;
    logic    known;
    result_t res;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [STEP_W-1:0] cfg_wdata_i;

  atr_item_if   item_if ();
  atr_result_if res_if ();

  alarm_timer_registers_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (res_if)
  );

  // Timer state as the block should hold it
  logic [TIME_W-1:0] now_us;
  logic [TIME_W-1:0] snap_us;
  logic [WORD_W-1:0] alarm_lo_w;
  logic [WORD_W-1:0] alarm_hi_w;
  logic              alarm_set;
  logic              irq_up;
  logic [STEP_W-1:0] step_us;

  result_t expected_results[$];
  int      errors;
  int      send_idle_pct;
  int      recv_stall_pct;
  logic    hold_req;
  int      hold_left;
  int      quiet_cycles;

  // Directed sequence, starting from reset with a step of one
  row_t dir_rows [0:23] = '{
    '{'{MODE_READ,  OFF_TIME_LOW,   32'h0},        1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_READ,  OFF_TIME_HIGH,  32'h0},        1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_TICK,  8'hff,          32'hffffffff}, 1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_READ,  OFF_TIME_LOW,   32'h0},        1'b1, '{32'h1, 1'b0, 1'b0}},
    '{'{MODE_READ,  8'h02,          32'h0},        1'b1, '{32'h0, 1'b0, 1'b1}},
    '{'{MODE_READ,  8'hff,          32'hffffffff}, 1'b1, '{32'h0, 1'b0, 1'b1}},
    '{'{MODE_WRITE, OFF_TIME_LOW,   32'hffffffff}, 1'b1, '{32'h0, 1'b0, 1'b1}},
    '{'{MODE_WRITE, OFF_TIME_HIGH,  32'h12345678}, 1'b1, '{32'h0, 1'b0, 1'b1}},
    '{'{MODE_RSVD,  OFF_ALARM_LOW,  32'h0},        1'b1, '{32'h0, 1'b0, 1'b1}},
    '{'{MODE_WRITE, OFF_ALARM_HIGH, 32'h0},        1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_ALARM_LOW,  32'h0},        1'b1, '{32'h0, 1'b1, 1'b0}},
    '{'{MODE_WRITE, OFF_CLEAR_IRQ,  32'hffffffff}, 1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_ALARM_LOW,  32'h3},        1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_TICK,  8'h00,          32'h0},        1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_TICK,  8'h55,          32'haaaaaaaa}, 1'b1, '{32'h0, 1'b1, 1'b0}},
    '{'{MODE_TICK,  8'haa,          32'h55555555}, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_CLEAR_ALRM, 32'h0},        1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_ALARM_HIGH, 32'hffffffff}, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_ALARM_LOW,  32'hffffffff}, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_CLEAR_ALRM, 32'h0},        1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_TICK,  8'h0f,          32'h0},        1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_ALARM_LOW,  32'ha},        1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_WRITE, OFF_CLEAR_IRQ,  32'h0},        1'b0, '{32'h0, 1'b0, 1'b0}},
    '{'{MODE_READ,  OFF_TIME_HIGH,  32'hffffffff}, 1'b1, '{32'h0, 1'b0, 1'b0}}
  };

  // Clock and reset
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Assembled alarm, cut to the counter width
  function automatic logic [TIME_W-1:0] alarm_at();
    logic [63:0] full;
    full = {alarm_hi_w, alarm_lo_w};
    return full[TIME_W-1:0];
  endfunction

  // Apply one item to the timer state and return the result it gives
  function automatic result_t timer_apply(item_t it);
    result_t     r;
    logic [63:0] snap_wide;
    r = '0;
    case (mode_e'(it.mode))
      MODE_TICK: begin
        now_us = now_us + TIME_W'(step_us);
        if (alarm_set && alarm_at() <= now_us) begin
          irq_up    = 1'b1;
          alarm_set = 1'b0;
        end
      end
      MODE_READ: begin
        if (it.offset == OFF_TIME_LOW) begin
          snap_us     = now_us;
          snap_wide   = 64'(snap_us);
          r.read_data = snap_wide[31:0];
        end else if (it.offset == OFF_TIME_HIGH) begin
          snap_wide   = 64'(snap_us);
          r.read_data = snap_wide[63:32];
        end else begin
          r.status = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (it.offset == OFF_ALARM_LOW) begin
          alarm_lo_w = it.write_data;
          if (alarm_at() <= now_us) irq_up = 1'b1;
          else alarm_set = 1'b1;
        end else if (it.offset == OFF_ALARM_HIGH) begin
          alarm_hi_w = it.write_data;
        end else if (it.offset == OFF_CLEAR_ALRM) begin
          alarm_set = 1'b0;
          irq_up    = 1'b0;
        end else if (it.offset == OFF_CLEAR_IRQ) begin
          irq_up = 1'b0;
        end else begin
          r.status = 1'b1;
        end
      end
      default: r.status = 1'b1;
    endcase
    r.irq_level = irq_up;
    return r;
  endfunction

  function automatic item_t bus_item(mode_e m, logic [OFF_W-1:0] off, logic [WORD_W-1:0] d);
    item_t it;
    it.mode       = m;
    it.offset     = off;
    it.write_data = d;
    return it;
  endfunction

  // Offer one item, with random idle cycles first, and record its expected result
  task automatic send_item(item_t it, logic known, result_t typed);
    result_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.mode       <= it.mode;
    item_if.offset     <= it.offset;
    item_if.write_data <= it.write_data;
    do @(posedge clk_i); while (!item_if.ready);
    p = timer_apply(it);
    expected_results.push_back(known ? typed : p);
  endtask

  // Stop offering and hold until every expected result has come back
  task automatic wait_for_results();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic set_tick_step(logic [STEP_W-1:0] v);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    step_us = v;
  endtask

  // Random traffic: ticks, time reads, alarm set-ups around the current time, clears, plus noise
  task automatic run_phase(logic [STEP_W-1:0] step, int idle, int stall, int n, bit hold);
    int            sent;
    int            k;
    int            delta;
    logic [63:0]   tgt;
    logic [63:0]   now_wide;
    result_t       none;
    none = '0;
    set_tick_step(step);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (hold) hold_req <= 1'b1;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(99);
      if (k < 35) begin
        send_item(bus_item(MODE_TICK, OFF_W'($urandom), $urandom), 1'b0, none);
        sent++;
      end else if (k < 46) begin
        send_item(bus_item(MODE_READ, OFF_TIME_LOW, $urandom), 1'b0, none);
        sent++;
      end else if (k < 54) begin
        send_item(bus_item(MODE_READ, OFF_TIME_HIGH, $urandom), 1'b0, none);
        sent++;
      end else if (k < 70) begin
        delta    = int'($urandom_range(15)) - 3;
        now_wide = 64'(now_us);
        tgt      = now_wide + 64'(longint'(delta) * longint'(step_us));
        if ($urandom_range(7) == 0) tgt[63:32] = $urandom;
        send_item(bus_item(MODE_WRITE, OFF_ALARM_HIGH, tgt[63:32]), 1'b0, none);
        send_item(bus_item(MODE_WRITE, OFF_ALARM_LOW, tgt[31:0]), 1'b0, none);
        sent += 2;
      end else if (k < 76) begin
        send_item(bus_item(MODE_WRITE, OFF_CLEAR_IRQ, $urandom), 1'b0, none);
        sent++;
      end else if (k < 81) begin
        send_item(bus_item(MODE_WRITE, OFF_CLEAR_ALRM, $urandom), 1'b0, none);
        sent++;
      end else if (k == 81) begin
        wait_for_results();
      end else begin
        send_item(bus_item(mode_e'($urandom_range(3)), OFF_W'($urandom), $urandom),
                  1'b0, none);
        sent++;
      end
    end
  endtask

  // Result side: random stalls, and one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: read_data %h irq_level %b status %b",
               res_if.read_data, res_if.irq_level, res_if.status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res_if.read_data !== e.read_data) begin
          $error("read_data: expected %h, got %h", e.read_data, res_if.read_data);
          errors++;
        end
        if (res_if.irq_level !== e.irq_level) begin
          $error("irq_level: expected %b, got %b", e.irq_level, res_if.irq_level);
          errors++;
        end
        if (res_if.status !== e.status) begin
          $error("status: expected %b, got %b", e.status, res_if.status);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    item_if.valid      = 1'b0;
    item_if.mode       = MODE_TICK;
    item_if.offset     = '0;
    item_if.write_data = '0;
    hold_req           = 1'b0;
    quiet_cycles       = 0;
    errors             = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    now_us             = '0;
    snap_us            = '0;
    alarm_lo_w         = '0;
    alarm_hi_w         = '0;
    alarm_set          = 1'b0;
    irq_up             = 1'b0;
    step_us            = STEP_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset step
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].res);

    // Random phases across steps and idling patterns
    run_phase(20'd1000000, 0, 0, 150, 1'b1);
    run_phase(20'd0, 88, 0, 100, 1'b0);
    run_phase(20'hfffff, 0, 88, 120, 1'b0);
    run_phase(20'd1, 27, 27, 150, 1'b0);
    run_phase(20'($urandom_range(1000000, 2)), 0, 0, 130, 1'b0);
    run_phase(20'($urandom_range(64, 1)), 27, 27, 100, 1'b0);

    // Drain and let any stray result show up
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/atr_pkg.sv
hw/rtl/atr_if.sv
hw/rtl/atr_in_stage.sv
hw/rtl/atr_core.sv
hw/rtl/atr_out_stage.sv
hw/rtl/alarm_timer_registers_top.sv
hw/rtl/atr_checker.sv
dv/alarm_timer_registers_top_test.sv
